// ===== rtl/bfd_pkg.sv =====
// Package for the box filter image downscaler.
// Holds widths, register codes, word types and the reciprocal table.
// No dependencies.
`default_nettype none

package bfd_pkg;

  // Limits of the frame geometry and of the block side.
  localparam int unsigned MAX_WIDTH  = 2048;
  localparam int unsigned MAX_HEIGHT = 4096;
  localparam int unsigned MAX_FACTOR = 8;

  // Field and counter widths.
  localparam int unsigned PIX_W    = 8;
  localparam int unsigned FACTOR_W = 4;
  localparam int unsigned CIB_W    = 3;
  localparam int unsigned COL_W    = 11;
  localparam int unsigned ROW_W    = 12;
  localparam int unsigned WIDTH_W  = 12;
  localparam int unsigned HEIGHT_W = 13;
  localparam int unsigned CFG_W    = 13;
  localparam int unsigned CFG_IDX_W = 2;

  // Sum of one block row (at most MAX_FACTOR pixels) and of one block.
  localparam int unsigned HSUM_W = PIX_W + CIB_W;
  localparam int unsigned SUM_W  = PIX_W + 2 * CIB_W;

  // Reciprocal of the block area, scaled by 2^RECIP_SHIFT and rounded up.
  localparam int unsigned RECIP_SHIFT = 20;
  localparam int unsigned RECIP_W     = RECIP_SHIFT + 1;
  localparam int unsigned PROD_W      = SUM_W + RECIP_W;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BLOCK_FACTOR  = 2'd0,
    CFG_SOURCE_WIDTH  = 2'd1,
    CFG_SOURCE_HEIGHT = 2'd2
  } cfg_idx_e;

  // Input word: one source pixel.
  typedef struct packed {
    logic [PIX_W-1:0] red_in;
    logic [PIX_W-1:0] green_in;
    logic [PIX_W-1:0] blue_in;
  } pix_in_t;

  // Output word: one downscaled pixel.
  typedef struct packed {
    logic [PIX_W-1:0] red_out;
    logic [PIX_W-1:0] green_out;
    logic [PIX_W-1:0] blue_out;
    logic [COL_W-1:0] out_column;
    logic [ROW_W-1:0] out_row;
    logic             frame_end;
  } pix_out_t;

  // Column accumulator request: one finished block row of one block.
  typedef struct packed {
    logic                        valid;
    logic                        first;
    logic                        emit;
    logic                        last;
    logic [COL_W-1:0]            col;
    logic [ROW_W-1:0]            row;
    logic [2:0][HSUM_W-1:0]      hsum;
  } acc_req_t;

  // Column accumulator result: one finished block sum.
  typedef struct packed {
    logic                        valid;
    logic                        last;
    logic [COL_W-1:0]            col;
    logic [ROW_W-1:0]            row;
    logic [2:0][SUM_W-1:0]       sum;
  } acc_res_t;

  // ceil(2^RECIP_SHIFT / (f*f)); exact truncated quotient for every block sum.
  function automatic logic [RECIP_W-1:0] recip(input logic [FACTOR_W-1:0] f);
    logic [RECIP_W-1:0] r;
    case (f)
      4'd1:    r = 21'd1048576;
      4'd2:    r = 21'd262144;
      4'd3:    r = 21'd116509;
      4'd4:    r = 21'd65536;
      4'd5:    r = 21'd41944;
      4'd6:    r = 21'd29128;
      4'd7:    r = 21'd21400;
      4'd8:    r = 21'd16384;
      default: r = 21'd1048576;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/box_filter_image_downscaler.sv =====
// Top level of the box filter image downscaler.
// Depends on bfd_pkg and bfd_colacc.
//
//   channel  direction  handshake            word
//   cfg      in         cfg_we_i             cfg_idx_i, cfg_data_i
//   in       in         in_valid_i/stall_o   in_data_i  (one source pixel)
//   out      out        out_valid_o/stall_i  out_data_o (one block average)
//
// One source pixel is taken every cycle while the output side keeps up.
// After its last pixel, a block average passes the column memory read,
// the add and write back, then the reciprocal multiply into the output
// register. A stalled output register freezes the whole pipe and stalls
// the input. Reset puts the frame position at pixel zero and loads the
// default geometry; the column memory needs no clearing since the first
// block row of each block overwrites its entry.
`default_nettype none

module box_filter_image_downscaler (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [bfd_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [bfd_pkg::CFG_W-1:0]          cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  bfd_pkg::pix_in_t                   in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output bfd_pkg::pix_out_t                  out_data_o
);
  import bfd_pkg::*;

  // Configuration registers.
  logic [FACTOR_W-1:0] cfg_f_q;
  logic [WIDTH_W-1:0]  cfg_w_q;
  logic [HEIGHT_W-1:0] cfg_h_q;
  logic                restart;

  // Frame position.
  logic [COL_W-1:0]  col_q, col_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [CIB_W-1:0]  cib_q, cib_d;
  logic [CIB_W-1:0]  rib_q, rib_d;
  logic [COL_W-1:0]  bcol_q, bcol_d;
  logic [ROW_W-1:0]  brow_q, brow_d;
  logic [2:0][HSUM_W-1:0] hsum_q, hsum_d;

  // Clamped geometry and block tests.
  logic [FACTOR_W-1:0] f_cl;
  logic [WIDTH_W-1:0]  w_cl;
  logic [HEIGHT_W-1:0] h_cl;
  logic [CIB_W-1:0]    f_m1;
  logic [COL_W-1:0]    col_base;
  logic [ROW_W-1:0]    row_base;
  logic                whole_col, whole_row, last_col, last_row;
  logic                col_end, row_end, cib_last, rib_last;
  logic                in_block;

  logic        adv;
  logic        accept;
  acc_req_t    req;
  acc_res_t    res;

  logic [2:0][PROD_W-1:0] prod;
  logic [RECIP_W-1:0]     rcp;
  logic                   out_valid_q;
  pix_out_t               out_q;

  // Hold everything while a finished word waits at a stalled output.
  assign adv        = !out_valid_q || !out_stall_i;
  assign accept     = in_valid_i && adv;
  assign in_stall_o = !adv;

  // Configuration writes; any known register also restarts the frame.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_f_q <= FACTOR_W'(2);
      cfg_w_q <= WIDTH_W'(640);
      cfg_h_q <= HEIGHT_W'(480);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BLOCK_FACTOR:  cfg_f_q <= cfg_data_i[FACTOR_W-1:0];
        CFG_SOURCE_WIDTH:  cfg_w_q <= cfg_data_i[WIDTH_W-1:0];
        CFG_SOURCE_HEIGHT: cfg_h_q <= cfg_data_i[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  assign restart = cfg_we_i &&
                   (cfg_idx_i inside {CFG_BLOCK_FACTOR, CFG_SOURCE_WIDTH, CFG_SOURCE_HEIGHT});

  // Clamp geometry: zero means one, oversize saturates.
  always_comb begin
    if (cfg_f_q == '0) begin
      f_cl = FACTOR_W'(1);
    end else if (cfg_f_q > FACTOR_W'(MAX_FACTOR)) begin
      f_cl = FACTOR_W'(MAX_FACTOR);
    end else begin
      f_cl = cfg_f_q;
    end
    if (cfg_w_q == '0) begin
      w_cl = WIDTH_W'(1);
    end else if (cfg_w_q > WIDTH_W'(MAX_WIDTH)) begin
      w_cl = WIDTH_W'(MAX_WIDTH);
    end else begin
      w_cl = cfg_w_q;
    end
    if (cfg_h_q == '0) begin
      h_cl = HEIGHT_W'(1);
    end else if (cfg_h_q > HEIGHT_W'(MAX_HEIGHT)) begin
      h_cl = HEIGHT_W'(MAX_HEIGHT);
    end else begin
      h_cl = cfg_h_q;
    end
  end

  // Block tests: a block counts only if it lies wholly inside the frame,
  // and it is the last one along an axis if the next one would not fit.
  always_comb begin
    logic [FACTOR_W-1:0] fm1_full;
    fm1_full  = f_cl - FACTOR_W'(1);
    f_m1      = fm1_full[CIB_W-1:0];
    col_base  = col_q - COL_W'(cib_q);
    row_base  = row_q - ROW_W'(rib_q);
    whole_col = (13'(col_base) + 13'(f_cl)) <= 13'(w_cl);
    whole_row = (14'(row_base) + 14'(f_cl)) <= 14'(h_cl);
    last_col  = (13'(col_base) + 13'(f_cl) + 13'(f_cl)) > 13'(w_cl);
    last_row  = (14'(row_base) + 14'(f_cl) + 14'(f_cl)) > 14'(h_cl);
    col_end   = WIDTH_W'(col_q) == (w_cl - WIDTH_W'(1));
    row_end   = HEIGHT_W'(row_q) == (h_cl - HEIGHT_W'(1));
    cib_last  = cib_q == f_m1;
    rib_last  = rib_q == f_m1;
    in_block  = whole_col && whole_row;
  end

  // Advance the source position and the running block-row sum.
  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    cib_d  = cib_q;
    rib_d  = rib_q;
    bcol_d = bcol_q;
    brow_d = brow_q;
    hsum_d = hsum_q;
    if (accept && in_block) begin
      if (cib_q == '0) begin
        hsum_d[0] = HSUM_W'(in_data_i.red_in);
        hsum_d[1] = HSUM_W'(in_data_i.green_in);
        hsum_d[2] = HSUM_W'(in_data_i.blue_in);
      end else begin
        hsum_d[0] = hsum_q[0] + HSUM_W'(in_data_i.red_in);
        hsum_d[1] = hsum_q[1] + HSUM_W'(in_data_i.green_in);
        hsum_d[2] = hsum_q[2] + HSUM_W'(in_data_i.blue_in);
      end
    end
    if (accept) begin
      if (col_end) begin
        col_d  = '0;
        cib_d  = '0;
        bcol_d = '0;
        if (row_end) begin
          row_d  = '0;
          rib_d  = '0;
          brow_d = '0;
        end else begin
          row_d  = row_q + ROW_W'(1);
          rib_d  = rib_last ? '0 : rib_q + CIB_W'(1);
          brow_d = brow_q + ROW_W'(rib_last);
        end
      end else begin
        col_d  = col_q + COL_W'(1);
        cib_d  = cib_last ? '0 : cib_q + CIB_W'(1);
        bcol_d = bcol_q + COL_W'(cib_last);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      cib_q  <= '0;
      rib_q  <= '0;
      bcol_q <= '0;
      brow_q <= '0;
    end else if (restart) begin
      col_q  <= '0;
      row_q  <= '0;
      cib_q  <= '0;
      rib_q  <= '0;
      bcol_q <= '0;
      brow_q <= '0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      cib_q  <= cib_d;
      rib_q  <= rib_d;
      bcol_q <= bcol_d;
      brow_q <= brow_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hsum_q <= hsum_d;
  end

  // A finished block row goes to the column memory with the new pixel added.
  always_comb begin
    req.valid = accept && in_block && cib_last;
    req.first = rib_q == '0;
    req.emit  = rib_last;
    req.last  = last_col && last_row;
    req.col   = bcol_q;
    req.row   = brow_q;
    req.hsum  = hsum_d;
  end

  bfd_colacc u_colacc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .req_i  (req),
    .res_o  (res)
  );

  // Divide by the block area: multiply by the rounded-up reciprocal.
  always_comb begin
    rcp = recip(f_cl);
    for (int k = 0; k < 3; k++) begin
      prod[k] = PROD_W'(res.sum[k]) * PROD_W'(rcp);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && res.valid) begin
      out_q.red_out    <= prod[0][RECIP_SHIFT +: PIX_W];
      out_q.green_out  <= prod[1][RECIP_SHIFT +: PIX_W];
      out_q.blue_out   <= prod[2][RECIP_SHIFT +: PIX_W];
      out_q.out_column <= res.col;
      out_q.out_row    <= res.row;
      out_q.frame_end  <= res.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ===== rtl/bfd_colacc.sv =====
// Column accumulator of the box filter image downscaler.
// Per-column block sums in one synchronous memory; depends on bfd_pkg.
`default_nettype none

module bfd_colacc (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              adv_i,
  input  bfd_pkg::acc_req_t req_i,
  output bfd_pkg::acc_res_t res_o
);
  import bfd_pkg::*;

  logic [2:0][SUM_W-1:0] col_mem_q [MAX_WIDTH];
  logic [2:0][SUM_W-1:0] rd_q;
  logic [2:0][SUM_W-1:0] fwd_sum_q;
  logic [2:0][SUM_W-1:0] old_sum;
  logic [2:0][SUM_W-1:0] new_sum;
  logic                  fwd_q;
  acc_req_t              b_q;
  acc_res_t              res_q;

  // Read-modify-write: the entry read into rd_q when this block row was registered gets the row added.
  always_comb begin
    old_sum = fwd_q ? fwd_sum_q : rd_q;
    for (int k = 0; k < 3; k++) begin
      if (b_q.first) begin
        new_sum[k] = SUM_W'(b_q.hsum[k]);
      end else begin
        new_sum[k] = old_sum[k] + SUM_W'(b_q.hsum[k]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      if (req_i.valid) begin
        rd_q <= col_mem_q[req_i.col];
      end
      if (b_q.valid) begin
        col_mem_q[b_q.col] <= new_sum;
      end
      fwd_sum_q <= new_sum;
    end
  end

  // Forward the word being written when the same entry is read in that cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
      b_q   <= '0;
      res_q <= '0;
    end else if (adv_i) begin
      fwd_q       <= b_q.valid && req_i.valid && (b_q.col == req_i.col);
      b_q         <= req_i;
      res_q.valid <= b_q.valid && b_q.emit;
      res_q.last  <= b_q.last;
      res_q.col   <= b_q.col;
      res_q.row   <= b_q.row;
      res_q.sum   <= new_sum;
    end
  end

  assign res_o = res_q;

endmodule

`default_nettype wire
